[hdl/rtpm_pkg.sv]
// Shared types and constants for the resistive touch point mapper.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rtpm_pkg;

    localparam int COORD_W   = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;

    // serial divider: 24-bit dividend, 16-bit divisor, one quotient bit per cycle
    localparam int DIV_W     = 24;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // serial multiplier: 12 x 12, one multiplier bit per cycle
    localparam int MUL_W     = 12;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_RANGE       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RANGE       = 4'd7;

    localparam logic [COORD_W-1:0] FULL_SCALE = 12'd4095;

    // per-axis calibration handed to an axis mapper
    typedef struct packed {
        logic [COORD_W-1:0] size;
        logic [CFG_W-1:0]   offset;
        logic [CFG_W-1:0]   span;
    } axis_cfg_t;

    // handshake between an axis mapper and a serial unit
    typedef struct packed {
        logic start;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

[hdl/rtpm_serial_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on rtpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpm_serial_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rtpm_pkg::unit_req_t           req,
    input  wire logic [rtpm_pkg::DIV_W-1:0]    dividend,
    input  wire logic [rtpm_pkg::DVS_W-1:0]    divisor,
    output rtpm_pkg::unit_stat_t               stat,
    output logic      [rtpm_pkg::DIV_W-1:0]    quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rtpm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rtpm_pkg::DIV_W-1:0]       work_reg, work_next;
    logic [rtpm_pkg::DVS_W-1:0]       rem_reg, rem_next;
    logic [rtpm_pkg::DVS_W-1:0]       dvs_reg, dvs_next;
    logic [rtpm_pkg::DVS_W:0]         shifted;
    logic                             fits;

    assign shifted = {rem_reg, work_reg[rtpm_pkg::DIV_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? rtpm_pkg::DVS_W'(shifted - {1'b0, dvs_reg})
                             : shifted[rtpm_pkg::DVS_W-1:0];
            work_next = {work_reg[rtpm_pkg::DIV_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == rtpm_pkg::DIV_CNT_W'(rtpm_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

`default_nettype wire

[hdl/rtpm_serial_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rtpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpm_serial_mul (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rtpm_pkg::unit_req_t           req,
    input  wire logic [rtpm_pkg::MUL_W-1:0]    mplier,
    input  wire logic [rtpm_pkg::MUL_W-1:0]    mcand,
    output rtpm_pkg::unit_stat_t               stat,
    output logic      [rtpm_pkg::PROD_W-1:0]   product
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rtpm_pkg::MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rtpm_pkg::MUL_W-1:0]       mplier_reg, mplier_next;
    logic [rtpm_pkg::PROD_W-1:0]      mcand_reg, mcand_next;
    logic [rtpm_pkg::PROD_W-1:0]      acc_reg, acc_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mplier_next = mplier;
            mcand_next  = rtpm_pkg::PROD_W'(mcand);
            acc_next    = '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[rtpm_pkg::PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[rtpm_pkg::MUL_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == rtpm_pkg::MUL_CNT_W'(rtpm_pkg::MUL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

`default_nettype wire

[hdl/rtpm_axis_map.sv]
// One axis of the mapper: average, offset, scale and clamp, sequenced over
// a serial divider and a serial multiplier. Depends on rtpm_pkg and both units.
`timescale 1ns / 1ps
`default_nettype none

module rtpm_axis_map #(
    parameter int NUM_SAMPLES = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [11+$clog2(NUM_SAMPLES):0]      sum,
    input  wire rtpm_pkg::axis_cfg_t                  cal,
    output logic                                      busy,
    output logic      [rtpm_pkg::COORD_W-1:0]         point
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_AVG  = 3'd1;
    localparam logic [2:0] A_DIFF = 3'd2;
    localparam logic [2:0] A_MUL  = 3'd3;
    localparam logic [2:0] A_QUO  = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [rtpm_pkg::COORD_W-1:0]     avg_reg, avg_next;
    logic [rtpm_pkg::COORD_W-1:0]     point_reg, point_next;

    rtpm_pkg::unit_req_t              div_req, mul_req;
    rtpm_pkg::unit_stat_t             div_stat, mul_stat;
    logic [rtpm_pkg::DIV_W-1:0]       div_dvd, div_quo;
    logic [rtpm_pkg::DVS_W-1:0]       div_dvs;
    logic [rtpm_pkg::PROD_W-1:0]      mul_prod;
    logic [rtpm_pkg::MUL_W-1:0]       diff;
    logic                             below_off;

    // negative difference clamps to zero, so only avg >= offset is scaled
    assign below_off = ({{(rtpm_pkg::CFG_W - rtpm_pkg::COORD_W){1'b0}}, avg_reg} < cal.offset);
    assign diff      = avg_reg - cal.offset[rtpm_pkg::COORD_W-1:0];

    always_comb begin
        state_next    = state_reg;
        avg_next      = avg_reg;
        point_next    = point_reg;
        div_req.start = 1'b0;
        mul_req.start = 1'b0;
        div_dvd       = rtpm_pkg::DIV_W'(sum);
        div_dvs       = rtpm_pkg::DVS_W'(NUM_SAMPLES);
        unique case (state_reg)
            A_IDLE: begin
                if (start) begin
                    div_req.start = 1'b1;
                    state_next    = A_AVG;
                end
            end
            A_AVG: begin
                if (div_stat.done) begin
                    avg_next   = div_quo[rtpm_pkg::COORD_W-1:0];
                    state_next = A_DIFF;
                end
            end
            A_DIFF: begin
                if (below_off || (cal.span == '0)) begin
                    point_next = '0;
                    state_next = A_IDLE;
                end else begin
                    mul_req.start = 1'b1;
                    state_next    = A_MUL;
                end
            end
            A_MUL: begin
                div_dvd = mul_prod;
                div_dvs = cal.span;
                if (mul_stat.done) begin
                    div_req.start = 1'b1;
                    state_next    = A_QUO;
                end
            end
            A_QUO: begin
                if (div_stat.done) begin
                    if (div_quo > rtpm_pkg::DIV_W'(cal.size)) begin
                        point_next = cal.size;
                    end else begin
                        point_next = div_quo[rtpm_pkg::COORD_W-1:0];
                    end
                    state_next = A_IDLE;
                end
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg   <= avg_next;
        point_reg <= point_next;
    end

    rtpm_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    rtpm_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .mplier  (diff),
        .mcand   (cal.size),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    assign busy  = (state_reg != A_IDLE);
    assign point = point_reg;

endmodule

`default_nettype wire

[hdl/resistive_touch_point_mapper.sv]
// Top level of the resistive touch point mapper: sample intake, touch test,
// burst accumulation and output register. Depends on rtpm_pkg, rtpm_axis_map.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - s_* channel: one converter sample set per request (raw x, raw y, z1, z2).
//   A sample is registered on acceptance, then tested for touch and
//   accumulated in the next state. s_ready is high whenever the sequencer is idle.
// - A sample whose offset-corrected pressure is not strictly between the
//   threshold and 4096 clears the running sums and count; nothing is sent.
// - The NUM_SAMPLES-th touched sample in a row starts the two axis mappers
//   (running side by side). Each runs its serial divider for the average,
//   one serial multiply and a second divide, and skips the multiply and the
//   second divide when its span is zero or its average is below its offset.
// - m_* channel: one point per request, held in an output register. New
//   samples are taken while a point waits; a finished burst waits in the
//   mapping state until the output register is free.
// - cfg_* channel: always ready, index per the register list, data in the
//   low bits. Write only while the block is idle.
// - Reset (aresetn low, synchronous) loads register defaults, clears sums,
//   count and any pending point.
module resistive_touch_point_mapper #(
    parameter int NUM_SAMPLES = 32,
    parameter int ROTATION    = 0
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rtpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rtpm_pkg::CFG_W-1:0]          cfg_data,
    // sample requests
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rtpm_pkg::COORD_W-1:0]        s_raw_x,
    input  wire logic [rtpm_pkg::COORD_W-1:0]        s_raw_y,
    input  wire logic [rtpm_pkg::COORD_W-1:0]        s_pressure_z1,
    input  wire logic [rtpm_pkg::COORD_W-1:0]        s_pressure_z2,
    // point requests
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [rtpm_pkg::COORD_W-1:0]        m_point_x,
    output logic      [rtpm_pkg::COORD_W-1:0]        m_point_y
);

    localparam int SUM_W = 12 + $clog2(NUM_SAMPLES);
    localparam int CNT_W = $clog2(NUM_SAMPLES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROC  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_MAP   = 2'd3;

    // configuration registers
    logic [rtpm_pkg::COORD_W-1:0] width_reg, height_reg;
    logic [rtpm_pkg::CFG_W-1:0]   thresh_reg, poff_reg;
    logic [rtpm_pkg::CFG_W-1:0]   xoff_reg, yoff_reg, xrange_reg, yrange_reg;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next, count_inc;
    logic [SUM_W-1:0]             sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]             sum_y_reg, sum_y_next;

    // registered sample
    logic [rtpm_pkg::COORD_W-1:0] rx_reg, ry_reg, z1_reg, z2_reg;

    logic                         m_valid_reg, m_valid_next;
    logic [rtpm_pkg::COORD_W-1:0] m_point_x_reg, m_point_y_reg;

    logic [rtpm_pkg::COORD_W-1:0] z2_inv, press;
    logic [rtpm_pkg::CFG_W-1:0]   z_corr;
    logic                         touched;
    logic [rtpm_pkg::COORD_W-1:0] sx, sy;

    logic                         s_accept, map_start, out_load;
    logic                         x_busy, y_busy;
    logic [rtpm_pkg::COORD_W-1:0] x_point, y_point;
    rtpm_pkg::axis_cfg_t          x_cal, y_cal;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign map_start = (state_reg == ST_START);

    // ---- configuration port ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd800;
            height_reg <= 12'd480;
            thresh_reg <= '0;
            poff_reg   <= '0;
            xoff_reg   <= '0;
            yoff_reg   <= '0;
            xrange_reg <= 16'd4095;
            yrange_reg <= 16'd4095;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rtpm_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data[rtpm_pkg::COORD_W-1:0];
                rtpm_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data[rtpm_pkg::COORD_W-1:0];
                rtpm_pkg::REG_PRESS_THRESH:  thresh_reg <= cfg_data;
                rtpm_pkg::REG_PRESS_OFFSET:  poff_reg   <= cfg_data;
                rtpm_pkg::REG_X_OFFSET:      xoff_reg   <= cfg_data;
                rtpm_pkg::REG_Y_OFFSET:      yoff_reg   <= cfg_data;
                rtpm_pkg::REG_X_RANGE:       xrange_reg <= cfg_data;
                rtpm_pkg::REG_Y_RANGE:       yrange_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- touch test on the registered sample ----
    // 4095 - z2 is the bitwise inverse of a 12-bit value
    assign z2_inv  = ~z2_reg;
    assign press   = (z1_reg > z2_inv) ? z1_reg : z2_inv;
    assign z_corr  = rtpm_pkg::CFG_W'(press) - poff_reg;
    assign touched = (z_corr > thresh_reg) &&
                     (z_corr[rtpm_pkg::CFG_W-1:rtpm_pkg::COORD_W] == '0);

    // ---- build-time rotation ----
    always_comb begin
        case (ROTATION[1:0])
            2'd0: begin
                sx = rtpm_pkg::FULL_SCALE - rx_reg;
                sy = rtpm_pkg::FULL_SCALE - ry_reg;
            end
            2'd1: begin
                sx = rtpm_pkg::FULL_SCALE - ry_reg;
                sy = rx_reg;
            end
            2'd2: begin
                sx = rx_reg;
                sy = ry_reg;
            end
            default: begin
                sx = ry_reg;
                sy = rtpm_pkg::FULL_SCALE - rx_reg;
            end
        endcase
    end

    assign count_inc = count_reg + 1'b1;
    assign out_load  = (state_reg == ST_MAP) && !x_busy && !y_busy &&
                       (!m_valid_reg || m_ready);

    // ---- sequencer ----
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (!touched) begin
                    sum_x_next = '0;
                    sum_y_next = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    sum_x_next = sum_x_reg + SUM_W'(sx);
                    sum_y_next = sum_y_reg + SUM_W'(sy);
                    count_next = count_inc;
                    state_next = (count_inc == CNT_W'(NUM_SAMPLES)) ? ST_START : ST_IDLE;
                end
            end
            ST_START: begin
                state_next = ST_MAP;
            end
            ST_MAP: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    sum_x_next   = '0;
                    sum_y_next   = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rx_reg <= s_raw_x;
            ry_reg <= s_raw_y;
            z1_reg <= s_pressure_z1;
            z2_reg <= s_pressure_z2;
        end
        if (out_load) begin
            m_point_x_reg <= x_point;
            m_point_y_reg <= y_point;
        end
    end

    // ---- axis mappers ----
    assign x_cal.size   = width_reg;
    assign x_cal.offset = xoff_reg;
    assign x_cal.span   = xrange_reg;
    assign y_cal.size   = height_reg;
    assign y_cal.offset = yoff_reg;
    assign y_cal.span   = yrange_reg;

    rtpm_axis_map #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_map_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .sum     (sum_x_reg),
        .cal     (x_cal),
        .busy    (x_busy),
        .point   (x_point)
    );

    rtpm_axis_map #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_map_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .sum     (sum_y_reg),
        .cal     (y_cal),
        .busy    (y_busy),
        .point   (y_point)
    );

    assign m_valid   = m_valid_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;

    // ---- assertions ----
    a_count_below_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count_reg < CNT_W'(NUM_SAMPLES)))
        else $error("burst count reached full length while idle");

    a_untouched_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROC && !touched) |=> (count_reg == '0 && sum_x_reg == '0
                                                && sum_y_reg == '0))
        else $error("untouched sample left burst state behind");

    a_start_axes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        map_start |-> (!x_busy && !y_busy))
        else $error("axis mapper started while busy");

    a_map_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        map_start |=> (x_busy && y_busy))
        else $error("axis mappers did not start");

    a_point_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_point_x <= width_reg && m_point_y <= height_reg))
        else $error("point exceeds screen size");

endmodule

`default_nettype wire
